// File: rtl/core/pcpg_pkg.sv
// ---------------------------------------------------------------------------
// pcpg_pkg
// shared types and constants of the palette chase pixel generator
// ---------------------------------------------------------------------------
package pcpg_pkg;

    localparam int STRIP_COUNT_DEF   = 22;
    localparam int PALETTE_DEPTH_DEF = 7;
    localparam int STEPS_PER_COLOR   = 10;
    localparam int BLEND_STEP        = 25;
    localparam int COLOR_W           = 24;
    localparam int CFG_IDX_W         = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_FIRST  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_LAST   = 4'd7;

    // one classified pixel handed from the front to the back
    typedef struct packed {
        logic [4:0] strip;
        logic [9:0] led;
        logic [2:0] idx;
        logic [2:0] nxt;
        logic [7:0] scale;
    } t_job;

endpackage

// File: rtl/core/palette_chase_pixel_generator.sv
// ---------------------------------------------------------------------------
// palette_chase_pixel_generator
// colours led slots from a chasing, blended palette
// ---------------------------------------------------------------------------
// channel   direction  handshake               payload
// input     in         i_valid / o_stall       i_strip_id, i_led_index, i_end_of_frame
// output    out        o_valid / i_stall       o_out_strip, o_out_led, o_red/green/blue
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one led slot per cycle sustained while o_stall is low; a taken request goes
// into the queue, then queue pop with palette read, then output register.
// a palette size write starts a pass of the remainder logic that re-reduces
// led count and chase offset; o_stall is high during it.
// reset is synchronous, no clearing pass.
// a stalled output backs up through a two-entry queue into o_stall.
// ---------------------------------------------------------------------------
module palette_chase_pixel_generator #(
    parameter int STRIP_COUNT   = pcpg_pkg::STRIP_COUNT_DEF,
    parameter int PALETTE_DEPTH = pcpg_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_strip_id,
    input  logic [9:0]                     i_led_index,
    input  logic                           i_end_of_frame,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [4:0]                     o_out_strip,
    output logic [9:0]                     o_out_led,
    output logic [7:0]                     o_red,
    output logic [7:0]                     o_green,
    output logic [7:0]                     o_blue,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pcpg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcpg_pkg::COLOR_W-1:0]   i_cfg_data
);
    import pcpg_pkg::*;

    localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [2:0]           r_pal_size;
    logic [2:0]           eff_size;
    logic                 size_wr;
    logic [CFG_IDX_W-1:0] pal_idx;
    logic                 pal_we;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_nonempty;
    t_job                 front_job;
    t_job                 queue_job;

    assign o_cfg_ready = 1'b1;
    assign size_wr     = i_cfg_valid && (i_cfg_index == CFG_PALETTE_SIZE);
    assign pal_idx     = i_cfg_index - CFG_COLOR_FIRST;
    assign pal_we      = i_cfg_valid && (i_cfg_index >= CFG_COLOR_FIRST)
                         && (i_cfg_index <= CFG_COLOR_LAST)
                         && (pal_idx < CFG_IDX_W'(PALETTE_DEPTH));

    // zero counts as one colour, larger sizes clamp to the palette depth
    always_comb begin
        eff_size = r_pal_size;
        if (eff_size == 3'd0) begin
            eff_size = 3'd1;
        end
        if (int'(eff_size) > PALETTE_DEPTH) begin
            eff_size = 3'(PALETTE_DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_size <= 3'd1;
        end else if (size_wr) begin
            r_pal_size <= i_cfg_data[2:0];
        end
    end

    pcpg_front #(
        .STRIP_COUNT (STRIP_COUNT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_strip_id     (i_strip_id),
        .i_led_index    (i_led_index),
        .i_end_of_frame (i_end_of_frame),
        .i_size         (eff_size),
        .i_size_wr      (size_wr),
        .i_queue_full   (q_full),
        .o_push         (q_push),
        .o_job          (front_job)
    );

    pcpg_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_job      (front_job),
        .i_pop      (q_pop),
        .o_job      (queue_job),
        .o_nonempty (q_nonempty),
        .o_full     (q_full)
    );

    pcpg_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .ADDR_W        (PAL_AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pal_we     (pal_we),
        .i_pal_addr   (pal_idx[PAL_AW-1:0]),
        .i_pal_data   (i_cfg_data),
        .i_job        (queue_job),
        .i_q_nonempty (q_nonempty),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_strip  (o_out_strip),
        .o_out_led    (o_out_led),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("pixel queue written while full");

    a_pass_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        size_wr |=> o_stall)
        else $error("input not held off during remainder pass");

    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_nonempty)
        else $error("pixel queue read while empty");
`endif

endmodule

// File: rtl/core/pcpg_ram.sv
// ---------------------------------------------------------------------------
// pcpg_ram
// generic ram, one write port, two registered read ports
// ---------------------------------------------------------------------------
module pcpg_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 7,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: rtl/core/pcpg_front.sv
// ---------------------------------------------------------------------------
// pcpg_front
// accepts led slots, tracks led count and chase offset, classifies pixels
// ---------------------------------------------------------------------------
module pcpg_front #(
    parameter int STRIP_COUNT = pcpg_pkg::STRIP_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_strip_id,
    input  logic [9:0]       i_led_index,
    input  logic             i_end_of_frame,
    input  logic [2:0]       i_size,
    input  logic             i_size_wr,
    input  logic             i_queue_full,
    output logic             o_push,
    output pcpg_pkg::t_job   o_job
);
    import pcpg_pkg::*;

    logic [15:0] r_count;
    logic [6:0]  r_cres;     // count mod modulus, accumulator during the pass
    logic [6:0]  r_offset;   // chase offset as stored
    logic [6:0]  r_ores;     // offset mod modulus, accumulator during the pass
    logic        r_busy;
    logic [3:0]  r_step;

    logic [6:0] modulus;
    logic       accept;
    logic       strip_ok;
    logic [7:0] pos_sum;
    logic [6:0] pos;
    logic [2:0] idx;
    logic [3:0] frac;
    logic [2:0] idx_inc;
    logic [6:0] cres_inc;
    logic [6:0] ores_inc;
    logic [6:0] off_next;
    logic [7:0] c_tmp;
    logic [6:0] c_red;
    logic [2:0] o_bit;
    logic [7:0] o_tmp;
    logic [6:0] o_red;

    assign modulus  = 7'(int'(i_size) * STEPS_PER_COLOR);
    assign o_stall  = r_busy || i_queue_full;
    assign accept   = i_valid && !o_stall;
    assign strip_ok = i_strip_id < 8'(STRIP_COUNT);

    assign pos_sum = {1'b0, r_cres} + {1'b0, r_ores};
    assign pos     = (pos_sum >= {1'b0, modulus}) ? 7'(pos_sum - {1'b0, modulus})
                                                  : pos_sum[6:0];

    // entry and step within entry from the palette position
    always_comb begin
        idx = '0;
        for (int k = 1; k < 7; k++) begin
            if (pos >= 7'(k * STEPS_PER_COLOR)) begin
                idx = 3'(k);
            end
        end
        frac = 4'(pos - 7'(int'(idx) * STEPS_PER_COLOR));
    end

    assign idx_inc = idx + 3'd1;

    assign cres_inc = r_cres + 7'd1;
    assign ores_inc = r_ores + 7'd1;
    assign off_next = (ores_inc == modulus) ? '0 : ores_inc;

    // restoring reduction, one bit of count and offset per cycle
    assign c_tmp = {r_cres, r_count[4'd15 - r_step]};
    assign c_red = (c_tmp >= {1'b0, modulus}) ? 7'(c_tmp - {1'b0, modulus}) : c_tmp[6:0];
    assign o_bit = 3'd6 - r_step[2:0];
    assign o_tmp = {r_ores, r_offset[o_bit]};
    assign o_red = (o_tmp >= {1'b0, modulus}) ? 7'(o_tmp - {1'b0, modulus}) : o_tmp[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cres   <= '0;
            r_offset <= '0;
            r_ores   <= '0;
            r_busy   <= 1'b0;
            r_step   <= '0;
        end else if (i_size_wr) begin
            r_busy <= 1'b1;
            r_step <= '0;
            r_cres <= '0;
            r_ores <= '0;
        end else if (r_busy) begin
            r_cres <= c_red;
            if (r_step < 4'd7) begin
                r_ores <= o_red;
            end
            r_step <= r_step + 4'd1;
            if (r_step == 4'd15) begin
                r_busy <= 1'b0;
            end
        end else if (accept) begin
            if (strip_ok) begin
                r_count <= r_count + 16'd1;
                if (r_count == 16'hFFFF || cres_inc == modulus) begin
                    r_cres <= '0;
                end else begin
                    r_cres <= cres_inc;
                end
            end
            if (i_end_of_frame) begin
                r_count  <= '0;
                r_cres   <= '0;
                r_offset <= off_next;
                r_ores   <= off_next;
            end
        end
    end

    assign o_push      = accept && strip_ok;
    assign o_job.strip = i_strip_id[4:0];
    assign o_job.led   = i_led_index;
    assign o_job.idx   = idx;
    assign o_job.nxt   = (idx_inc == i_size) ? 3'd0 : idx_inc;
    assign o_job.scale = 8'({4'd0, frac} * 8'(BLEND_STEP) + 8'd1);

endmodule

// File: rtl/core/pcpg_queue.sv
// ---------------------------------------------------------------------------
// pcpg_queue
// two-entry queue of classified pixels between front and back
// ---------------------------------------------------------------------------
module pcpg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pcpg_pkg::t_job i_job,
    input  logic           i_pop,
    output pcpg_pkg::t_job o_job,
    output logic           o_nonempty,
    output logic           o_full
);
    import pcpg_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_job      = r_mem[r_rptr];
    assign o_nonempty = r_count != 2'd0;
    assign o_full     = r_count == 2'd2;

endmodule

// File: rtl/core/pcpg_back.sv
// ---------------------------------------------------------------------------
// pcpg_back
// palette lookup and per-channel blend, output register
// ---------------------------------------------------------------------------
module pcpg_back #(
    parameter int PALETTE_DEPTH = pcpg_pkg::PALETTE_DEPTH_DEF,
    parameter int ADDR_W        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pal_we,
    input  logic [ADDR_W-1:0]             i_pal_addr,
    input  logic [pcpg_pkg::COLOR_W-1:0]  i_pal_data,
    input  pcpg_pkg::t_job                i_job,
    input  logic                          i_q_nonempty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [4:0]                    o_out_strip,
    output logic [9:0]                    o_out_led,
    output logic [7:0]                    o_red,
    output logic [7:0]                    o_green,
    output logic [7:0]                    o_blue
);
    import pcpg_pkg::*;

    logic [PALETTE_DEPTH-1:0] r_written;
    logic                     r_a_valid;
    t_job                     r_a_job;

    logic               out_free;
    logic               a_open;
    t_job               rd_job;
    logic [COLOR_W-1:0] rdata_a;
    logic [COLOR_W-1:0] rdata_b;
    logic [COLOR_W-1:0] c0;
    logic [COLOR_W-1:0] c1;

    function automatic logic [7:0] lerp(logic [7:0] a, logic [7:0] b, logic [7:0] scale);
        logic [15:0] prod;
        if (b > a) begin
            prod = (b - a) * scale;
            return a + prod[15:8];
        end
        prod = (a - b) * scale;
        return a - prod[15:8];
    endfunction

    assign out_free = !o_valid || !i_stall;
    assign a_open   = !r_a_valid || out_free;
    assign o_pop    = i_q_nonempty && a_open;

    // hold the read address while the read stage waits
    assign rd_job = o_pop ? i_job : r_a_job;

    pcpg_ram #(
        .WIDTH  (COLOR_W),
        .DEPTH  (PALETTE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_palette (
        .i_clk     (i_clk),
        .i_we      (i_pal_we),
        .i_waddr   (i_pal_addr),
        .i_wdata   (i_pal_data),
        .i_raddr_a (rd_job.idx[ADDR_W-1:0]),
        .i_raddr_b (rd_job.nxt[ADDR_W-1:0]),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // entries never written read as black
    assign c0 = r_written[r_a_job.idx[ADDR_W-1:0]] ? rdata_a : '0;
    assign c1 = r_written[r_a_job.nxt[ADDR_W-1:0]] ? rdata_b : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_a_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            if (i_pal_we) begin
                r_written[i_pal_addr] <= 1'b1;
            end
            if (a_open) begin
                r_a_valid <= o_pop;
            end
            if (out_free) begin
                o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_job <= i_job;
        end
        if (out_free && r_a_valid) begin
            o_out_strip <= r_a_job.strip;
            o_out_led   <= r_a_job.led;
            o_red       <= lerp(c0[23:16], c1[23:16], r_a_job.scale);
            o_green     <= lerp(c0[15:8], c1[15:8], r_a_job.scale);
            o_blue      <= lerp(c0[7:0], c1[7:0], r_a_job.scale);
        end
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// regression bench for the palette chase pixel generator: led slot requests
// are driven with random gaps and output backpressure, every pixel is checked
// field by field against a local model of the chase position and the
// blended palette, and the palette registers are reprogrammed between phases
// ---------------------------------------------------------------------------
module tb;
    import pcpg_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_TOP = 4'd15;

    typedef struct packed {
        logic [4:0] strip;
        logic [9:0] led;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [7:0]           i_strip_id;
    logic [9:0]           i_led_index;
    logic                 i_end_of_frame;
    logic                 o_valid;
    logic                 i_stall;
    logic [4:0]           o_out_strip;
    logic [9:0]           o_out_led;
    logic [7:0]           o_red;
    logic [7:0]           o_green;
    logic [7:0]           o_blue;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COLOR_W-1:0]   i_cfg_data;

    // local copy of the block's registers and chase state
    logic [2:0]         pal_size_reg;
    logic [COLOR_W-1:0] pal_color [PALETTE_DEPTH_DEF];
    logic [15:0]        led_count;
    logic [6:0]         chase_pos;

    pixel_t pixels_due [$];

    int  mismatches     = 0;
    int  pixels_checked = 0;
    int  slots_sent     = 0;
    int  reg_writes     = 0;
    int  cycle_count    = 0;
    int  hold_left      = 0;
    int  stall_left     = 0;
    bit  gaps_on        = 1'b1;

    palette_chase_pixel_generator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_strip_id     (i_strip_id),
        .i_led_index    (i_led_index),
        .i_end_of_frame (i_end_of_frame),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_strip    (o_out_strip),
        .o_out_led      (o_out_led),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycle_count, pixels_due.size());
            $display("palette_chase_pixel_generator regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // chase model
    // ---------------------------------------------------------------------
    function automatic logic [7:0] blend_channel(input int a, input int b, input int frac);
        if (b > a)
            return 8'(a + (((b - a) * (frac + 1)) >> 8));
        return 8'(a - (((a - b) * (frac + 1)) >> 8));
    endfunction

    task automatic advance_chase(input logic [7:0] strip, input logic [9:0] led,
                                 input logic eof);
        int           size;
        int           modulus;
        int           pos;
        int           idx;
        int           nxt;
        int           blend;
        logic [23:0]  c0;
        logic [23:0]  c1;
        pixel_t       px;
        size = (pal_size_reg == 3'd0) ? 1 : int'(pal_size_reg);
        if (size > PALETTE_DEPTH_DEF)
            size = PALETTE_DEPTH_DEF;
        modulus = size * STEPS_PER_COLOR;
        if (strip < STRIP_COUNT_DEF) begin
            pos   = (int'(led_count) + int'(chase_pos)) % modulus;
            idx   = pos / STEPS_PER_COLOR;
            nxt   = (idx + 1) % size;
            blend = (pos % STEPS_PER_COLOR) * BLEND_STEP;
            c0    = pal_color[idx];
            c1    = pal_color[nxt];
            px.strip = strip[4:0];
            px.led   = led;
            px.red   = blend_channel(int'(c0[23:16]), int'(c1[23:16]), blend);
            px.green = blend_channel(int'(c0[15:8]), int'(c1[15:8]), blend);
            px.blue  = blend_channel(int'(c0[7:0]), int'(c1[7:0]), blend);
            pixels_due.push_back(px);
            led_count = led_count + 16'd1;
        end
        // end of frame takes effect after the pixel of this slot
        if (eof) begin
            led_count = 16'd0;
            chase_pos = 7'(((int'(chase_pos) % modulus) + 1) % modulus);
        end
    endtask

    // ---------------------------------------------------------------------
    // pixel check
    // ---------------------------------------------------------------------
    task automatic report_pixel(input string why, input pixel_t want, input pixel_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("%s at cycle %0d: want strip %0d led %0d rgb %02h %02h %02h, ",
                   why, cycle_count, want.strip, want.led, want.red, want.green,
                   want.blue);
            $display("got strip %0d led %0d rgb %02h %02h %02h",
                     got.strip, got.led, got.red, got.green, got.blue);
        end
    endtask

    always @(posedge i_clk) begin : check_pixels
        pixel_t want;
        pixel_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.strip = o_out_strip;
            got.led   = o_out_led;
            got.red   = o_red;
            got.green = o_green;
            got.blue  = o_blue;
            pixels_checked++;
            if (pixels_due.size() == 0) begin
                report_pixel("pixel with none due", '0, got);
            end else begin
                want = pixels_due.pop_front();
                if (got.strip !== want.strip || got.led !== want.led ||
                    got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue)
                    report_pixel("pixel mismatch", want, got);
            end
        end
    end

    // ---------------------------------------------------------------------
    // receiver: random stalls, plus a long hold when a test asks for one
    // ---------------------------------------------------------------------
    function automatic int pick_len();
        if ($urandom_range(0, 9) < 8)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 30));
    endfunction

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else begin
                i_stall = 1'b0;
                if (gaps_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_len();
            end
        end
    end

    // ---------------------------------------------------------------------
    // sender and register writes
    // ---------------------------------------------------------------------
    function automatic int pick_gap();
        if (!gaps_on || $urandom_range(0, 9) < 6)
            return 0;
        return pick_len();
    endfunction

    function automatic logic [7:0] pick_strip();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(0, STRIP_COUNT_DEF - 1));
        return 8'($urandom_range(STRIP_COUNT_DEF, 255));
    endfunction

    function automatic logic [9:0] pick_led();
        return 10'($urandom_range(0, 1023));
    endfunction

    task automatic send_slot(input logic [7:0] strip, input logic [9:0] led,
                             input logic eof);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid        = 1'b1;
        i_strip_id     = strip;
        i_led_index    = led;
        i_end_of_frame = eof;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        advance_chase(strip, led, eof);
        slots_sent++;
    endtask

    // all pixels in, then enough cycles for a slot that makes no pixel
    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pixels_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
        @(negedge i_clk);
        i_valid     = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == CFG_PALETTE_SIZE)
            pal_size_reg = data[2:0];
        else if (idx >= CFG_COLOR_FIRST && idx <= CFG_COLOR_LAST)
            pal_color[idx - CFG_COLOR_FIRST] = data;
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic program_palette(input int size);
        int pick;
        set_reg(CFG_PALETTE_SIZE, COLOR_W'(size));
        for (int k = 0; k < PALETTE_DEPTH_DEF; k++) begin
            pick = int'($urandom_range(0, 9));
            if (pick < 2)
                set_reg(CFG_IDX_W'(int'(CFG_COLOR_FIRST) + k), 24'h000000);
            else if (pick < 4)
                set_reg(CFG_IDX_W'(int'(CFG_COLOR_FIRST) + k), 24'hFFFFFF);
            else
                set_reg(CFG_IDX_W'(int'(CFG_COLOR_FIRST) + k), COLOR_W'($urandom));
        end
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------
    // reset palette is one black entry
    task automatic test_reset_palette();
        send_slot(8'd0, 10'd0, 1'b0);
        send_slot(8'd21, 10'd1023, 1'b0);
        send_slot(8'd22, 10'd5, 1'b0);
        send_slot(8'd3, 10'd9, 1'b1);
    endtask

    // two entries, walk every blend step of both and the wrap back to entry 0
    task automatic test_blend_steps();
        settle();
        set_reg(CFG_PALETTE_SIZE, 24'd2);
        set_reg(CFG_COLOR_FIRST, 24'h00FF80);
        set_reg(CFG_IDX_W'(int'(CFG_COLOR_FIRST) + 1), 24'hFF0001);
        for (int k = 0; k < 20; k++)
            send_slot(8'(k), (k == 0) ? 10'd1023 : 10'(k * 51), 1'b0);
        send_slot(8'd22, 10'd1023, 1'b0);
        send_slot(8'd255, 10'd0, 1'b0);
        // end of frame on a valid slot still colours it with the old offset
        send_slot(8'd21, 10'd1023, 1'b1);
        // end of frame on an invalid strip
        send_slot(8'd128, 10'd512, 1'b1);
        send_slot(8'd0, 10'd0, 1'b0);
    endtask

    // size zero acts as one entry; indexes past the palette are ignored
    task automatic test_register_edges();
        settle();
        set_reg(CFG_PALETTE_SIZE, 24'd0);
        set_reg(CFG_COLOR_FIRST, 24'hFFFFFF);
        for (int k = int'(CFG_COLOR_LAST) + 1; k <= int'(CFG_INDEX_TOP); k++)
            set_reg(CFG_IDX_W'(k), (k % 2 != 0) ? 24'hFFFFFF : 24'h000000);
        for (int k = 0; k < 12; k++)
            send_slot(pick_strip(), pick_led(), k == 11);
    endtask

    // offset left above the modulus when the palette shrinks
    task automatic test_palette_shrink();
        settle();
        program_palette(3);
        for (int k = 0; k < 24; k++)
            send_slot(pick_strip(), pick_led(), 1'b1);
        settle();
        set_reg(CFG_PALETTE_SIZE, 24'd1);
        for (int k = 0; k < 12; k++)
            send_slot(pick_strip(), pick_led(), k == 11);
    endtask

    // receiver holds off while requests keep coming, so the input backs up
    task automatic test_backpressure();
        settle();
        program_palette(4);
        gaps_on   = 1'b0;
        hold_left = 80;
        for (int k = 0; k < 40; k++)
            send_slot(8'($urandom_range(0, STRIP_COUNT_DEF - 1)), pick_led(), k == 39);
        gaps_on = 1'b1;
    endtask

    // frames of random length, mostly valid strips, some stray frame ends
    task automatic test_random_frames();
        int phase_sizes [9] = '{7, 3, 1, 0, 5, 2, 6, 4, 7};
        int sent;
        int len;
        foreach (phase_sizes[p]) begin
            settle();
            program_palette(phase_sizes[p]);
            sent = 0;
            while (sent < 45) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                len = ($urandom_range(0, 4) == 0) ? int'($urandom_range(9, 40))
                                                   : int'($urandom_range(1, 8));
                for (int k = 0; k < len; k++)
                    send_slot(pick_strip(), pick_led(),
                              (k == len - 1) || ($urandom_range(0, 39) == 0));
                sent += len;
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_strip_id     = '0;
        i_led_index    = '0;
        i_end_of_frame = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        pal_size_reg   = 3'd1;
        foreach (pal_color[k])
            pal_color[k] = '0;
        led_count = '0;
        chase_pos = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_palette();
        test_blend_steps();
        test_register_edges();
        test_palette_shrink();
        test_backpressure();
        test_random_frames();
        settle();

        $display("%0d led slots sent, %0d pixels checked, %0d register writes",
                 slots_sent, pixels_checked, reg_writes);
        $display("run covered blend steps, invalid strips, palette shrink and backpressure");
        if (mismatches == 0 && pixels_due.size() == 0) begin
            $display("palette_chase_pixel_generator regression: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("palette_chase_pixel_generator regression: fail");
        end
        $finish;
    end

endmodule
